// ===== sv/canonical_huffman_codec_core_defines.svh =====
// Assertion macros for the canonical Huffman codec core.
// Depends on nothing; included by the top level, which supplies clk_i and rst_ni.
`ifndef CANONICAL_HUFFMAN_CODEC_CORE_DEFINES_SVH
`define CANONICAL_HUFFMAN_CODEC_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CHC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define CHC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define CHC_ASSERT_IMP(lbl, ante, cons, msg)
`define CHC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/chc_pkg.sv =====
// Shared types, codes and sizes of the canonical Huffman codec core.
// Depends on nothing.
package chc_pkg;
  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 15;
  localparam int SYM_W        = 8;
  localparam int CNT_W        = 9;
  localparam int TOT_W        = 25;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_BUILD  = 2'd1;
  localparam logic [1:0] REQ_DECODE = 2'd2;
  localparam logic [1:0] REQ_ENCODE = 2'd3;

  localparam logic [2:0] ST_BUILT    = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_DECODED  = 3'd2;
  localparam logic [2:0] ST_OVERLONG = 3'd3;
  localparam logic [2:0] ST_ENCODED  = 3'd4;
  localparam logic [2:0] ST_NOTREADY = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_KRAFT, S_KCHK, S_CODES, S_EMIT
  } state_e;

  typedef struct packed {
    logic acc;
    logic clr_en;
    logic cnt_clr;
    logic cnt_inc;
    logic scan_en;
    logic kraft_en;
    logic kchk;
    logic codes_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic cnt_end;
    logic tbl_ready;
    logic dec_hit;
    logic dec_over;
    logic build_ok;
    logic out_free;
  } stat_t;
endpackage

// ===== sv/chc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module chc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== sv/chc_ctrl.sv =====
// Controller state machine of the canonical Huffman codec core.
// Depends on chc_pkg.
module chc_ctrl import chc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] req_i,
  input  stat_t      stat_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o,
  output state_e     state_o
);
  state_e state_q, state_d;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign state_o    = state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (stat_i.cnt_last) state_d = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          case (req_i)
            REQ_BUILD:  state_d = S_SCAN;
            REQ_ENCODE: state_d = S_EMIT;
            REQ_DECODE: begin
              if (!stat_i.tbl_ready || stat_i.dec_hit || stat_i.dec_over) state_d = S_EMIT;
            end
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN:  if (stat_i.cnt_end) state_d = S_KRAFT;
      S_KRAFT: if (stat_i.cnt_end) state_d = S_KCHK;
      S_KCHK:  state_d = stat_i.build_ok ? S_CODES : S_EMIT;
      S_CODES: if (stat_i.cnt_end) state_d = S_EMIT;
      S_EMIT:  if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.acc = acc;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_IDLE:  cmd_o.cnt_clr = 1'b1;
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.cnt_inc = !stat_i.cnt_end;
        cmd_o.cnt_clr = stat_i.cnt_end;
      end
      S_KRAFT: begin
        cmd_o.kraft_en = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
      end
      S_KCHK: begin
        cmd_o.kchk    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
      end
      S_CODES: begin
        cmd_o.codes_en = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
      end
      S_EMIT:  cmd_o.emit = stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end
endmodule

// ===== sv/chc_datapath.sv =====
// Datapath of the canonical Huffman codec core: tables, build counters, decode walk
// and output register. Depends on chc_pkg and chc_ram.
module chc_datapath import chc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [1:0]       req_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic [3:0]       code_length_i,
  input  logic             stream_bit_i,
  input  logic             out_ready_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  output logic [2:0]       status_o,
  output logic [SYM_W-1:0] symbol_out_o,
  output logic [14:0]      code_bits_o,
  output logic [3:0]       code_len_o
);
  logic [CNT_W-1:0] cnt_q;
  logic             p_vld_q;
  logic [SYM_W-1:0] p_idx_q;
  logic [CNT_W-1:0] counts_q [16];
  logic [15:0]      next_q [16];
  logic [CNT_W-1:0] off_q [16];
  logic [15:0]      code_acc_q;
  logic [CNT_W-1:0] off_acc_q;
  logic [TOT_W-1:0] total_q;
  logic [3:0]       maxlen_q, longest_q;
  logic             bad_q, ready_q;
  logic [15:0]      wc_q, wf_q;
  logic [8:0]       wi_q;
  logic [3:0]       wl_q;
  logic [2:0]       res_q;
  logic             kval_q;
  logic             vld_q;
  logic [2:0]       st_q;
  logic [SYM_W-1:0] sym_q;
  logic [14:0]      cb_q;
  logic [3:0]       cl_q;

  logic             rd_step, acc_load, acc_build, acc_enc, acc_dec;
  logic [3:0]       lt_rdata;
  logic [14:0]      ct_rdata;
  logic [SYM_W-1:0] ss_rdata;
  logic             lt_we, ct_we, ss_we, lt_re;
  logic [SYM_W-1:0] lt_waddr, lt_raddr, ss_waddr;
  logic [3:0]       lt_wdata, kl, pl;
  logic [14:0]      ct_wdata;
  logic [3:0]       dn;
  logic [CNT_W-1:0] dcount;
  logic [15:0]      dcode, ddiff;
  logic [16:0]      dk;
  logic             hit, over, build_ok;

  assign acc_load  = cmd_i.acc && (req_i == REQ_LOAD);
  assign acc_build = cmd_i.acc && (req_i == REQ_BUILD);
  assign acc_enc   = cmd_i.acc && (req_i == REQ_ENCODE) && ready_q;
  assign acc_dec   = cmd_i.acc && (req_i == REQ_DECODE) && ready_q;
  assign rd_step   = (cmd_i.scan_en || cmd_i.codes_en) && !cnt_q[CNT_W-1];
  assign kl        = cnt_q[3:0] + 4'd1;
  assign pl        = lt_rdata;

  assign dn     = wl_q + 4'd1;
  assign dcount = counts_q[dn];
  assign dcode  = wc_q | {15'd0, stream_bit_i};
  assign ddiff  = dcode - wf_q;
  assign hit    = (dcode >= wf_q) && (ddiff < {7'd0, dcount});
  assign over   = !hit && (dn >= longest_q);
  assign dk     = {8'd0, wi_q} + {1'b0, ddiff};
  assign build_ok = !bad_q && (maxlen_q != 4'd0) &&
                    (total_q == (TOT_W'(1) << maxlen_q));

  assign lt_we    = cmd_i.clr_en || acc_load;
  assign lt_waddr = cmd_i.clr_en ? cnt_q[SYM_W-1:0] : symbol_i;
  assign lt_wdata = cmd_i.clr_en ? 4'd0 : code_length_i;
  assign lt_re    = rd_step || acc_enc;
  assign lt_raddr = acc_enc ? symbol_i : cnt_q[SYM_W-1:0];
  assign ct_we    = cmd_i.codes_en && p_vld_q;
  assign ct_wdata = (pl != 4'd0) ? next_q[pl][14:0] : 15'd0;
  assign ss_we    = cmd_i.codes_en && p_vld_q && (pl != 4'd0);
  assign ss_waddr = off_q[pl][SYM_W-1:0];

  chc_ram #(.WIDTH(4), .DEPTH(NUM_SYMBOLS)) u_len_ram (
    .clk_i, .we_i(lt_we), .waddr_i(lt_waddr), .wdata_i(lt_wdata),
    .re_i(lt_re), .raddr_i(lt_raddr), .rdata_o(lt_rdata)
  );
  chc_ram #(.WIDTH(15), .DEPTH(NUM_SYMBOLS)) u_code_ram (
    .clk_i, .we_i(ct_we), .waddr_i(p_idx_q), .wdata_i(ct_wdata),
    .re_i(acc_enc), .raddr_i(symbol_i), .rdata_o(ct_rdata)
  );
  chc_ram #(.WIDTH(SYM_W), .DEPTH(NUM_SYMBOLS)) u_sort_ram (
    .clk_i, .we_i(ss_we), .waddr_i(ss_waddr), .wdata_i(p_idx_q),
    .re_i(acc_dec && hit), .raddr_i(dk[SYM_W-1:0]), .rdata_o(ss_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      p_vld_q   <= 1'b0;
      ready_q   <= 1'b0;
      longest_q <= '0;
      wc_q      <= '0;
      wf_q      <= '0;
      wi_q      <= '0;
      wl_q      <= '0;
      vld_q     <= 1'b0;
    end else begin
      p_vld_q <= rd_step;
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (acc_load || acc_build) begin
        ready_q <= 1'b0;
        wc_q <= '0; wf_q <= '0; wi_q <= '0; wl_q <= '0;
      end else if (acc_dec) begin
        if (hit || over) begin
          wc_q <= '0; wf_q <= '0; wi_q <= '0; wl_q <= '0;
        end else begin
          wi_q <= wi_q + dcount;
          wf_q <= (wf_q + {7'd0, dcount}) << 1;
          wc_q <= dcode << 1;
          wl_q <= dn;
        end
      end
      if (cmd_i.kchk && build_ok) begin
        ready_q   <= 1'b1;
        longest_q <= maxlen_q;
      end
      if (cmd_i.emit) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q <= cnt_q[SYM_W-1:0];
    if (acc_build) begin
      for (int i = 0; i < 16; i++) counts_q[i] <= '0;
      maxlen_q   <= '0;
      bad_q      <= 1'b0;
      total_q    <= '0;
      code_acc_q <= '0;
      off_acc_q  <= '0;
    end
    if (cmd_i.scan_en && p_vld_q) begin
      if ({1'b0, pl} > 5'(MAX_CODE_LEN)) bad_q <= 1'b1;
      if (pl > maxlen_q) maxlen_q <= pl;
      if (pl != 4'd0) counts_q[pl] <= counts_q[pl] + CNT_W'(1);
    end
    if (cmd_i.kraft_en && !cnt_q[4]) begin
      if (kl <= maxlen_q) total_q <= (total_q << 1) + TOT_W'(counts_q[kl]);
      next_q[kl] <= (code_acc_q + 16'(counts_q[kl - 4'd1])) << 1;
      code_acc_q <= (code_acc_q + 16'(counts_q[kl - 4'd1])) << 1;
      off_q[kl]  <= off_acc_q + counts_q[kl - 4'd1];
      off_acc_q  <= off_acc_q + counts_q[kl - 4'd1];
    end
    if (ss_we) begin
      next_q[pl] <= next_q[pl] + 16'd1;
      off_q[pl]  <= off_q[pl] + CNT_W'(1);
    end
    if (cmd_i.kchk) res_q <= build_ok ? ST_BUILT : ST_REJECTED;
    if (cmd_i.acc && !ready_q) res_q <= ST_NOTREADY;
    if (acc_enc) res_q <= ST_ENCODED;
    if (acc_dec) begin
      res_q  <= hit ? ST_DECODED : ST_OVERLONG;
      kval_q <= (dk < 17'(NUM_SYMBOLS));
    end
    if (cmd_i.emit) begin
      st_q  <= res_q;
      sym_q <= (res_q == ST_DECODED && kval_q) ? ss_rdata : '0;
      cb_q  <= (res_q == ST_ENCODED) ? ct_rdata : '0;
      cl_q  <= (res_q == ST_ENCODED) ? lt_rdata : '0;
    end
  end

  assign stat_o.cnt_last  = &cnt_q[SYM_W-1:0];
  assign stat_o.cnt_end   = cmd_i.kraft_en ? (cnt_q[3:0] == 4'd14) : cnt_q[CNT_W-1];
  assign stat_o.tbl_ready = ready_q;
  assign stat_o.dec_hit   = hit;
  assign stat_o.dec_over  = over;
  assign stat_o.build_ok  = build_ok;
  assign stat_o.out_free  = !vld_q || out_ready_i;

  assign out_valid_o  = vld_q;
  assign status_o     = st_q;
  assign symbol_out_o = sym_q;
  assign code_bits_o  = cb_q;
  assign code_len_o   = cl_q;
endmodule

// ===== sv/canonical_huffman_codec_core.sv =====
// Top level of the canonical Huffman codec core: controller, datapath and checks.
// Depends on chc_pkg, chc_ctrl, chc_datapath and the defines header.
//
//   Channel  Direction  tdata                                    tuser
//   s_axis   in         symbol, code_length, stream_bit          req_type
//   m_axis   out        symbol_out, code_bits, code_len          status
//
// After reset a clearing pass zeroes all 256 length-table entries; no beat is taken then.
// A load, or a decode bit that does not end a code, leaves the engine idle with no result.
// Encode, not-ready answers and a decode bit that ends a code go to the emit state, where the
// result register takes the registered table reads. A build makes up to two passes over the
// length table through its single read port, the second only if the check after the 15-step
// Kraft sum accepts the table. A stalled result holds the engine.
`include "canonical_huffman_codec_core_defines.svh"
module canonical_huffman_codec_core import chc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // symbol, code_length, stream_bit, zero fill
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // symbol_out, code_bits, code_len, zero fill
  output logic [2:0]  m_axis_tuser   // status
);
  cmd_t       cmd;
  stat_t      stat;
  state_e     state;
  logic [7:0] symbol_out;
  logic [14:0] code_bits;
  logic [3:0] code_len;

  chc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .req_i(s_axis_tuser),
    .stat_i(stat), .in_ready_o(s_axis_tready), .cmd_o(cmd), .state_o(state)
  );

  chc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i(s_axis_tuser),
    .symbol_i(s_axis_tdata[7:0]), .code_length_i(s_axis_tdata[11:8]),
    .stream_bit_i(s_axis_tdata[12]), .out_ready_i(m_axis_tready),
    .stat_o(stat), .out_valid_o(m_axis_tvalid), .status_o(m_axis_tuser),
    .symbol_out_o(symbol_out), .code_bits_o(code_bits), .code_len_o(code_len)
  );

  assign m_axis_tdata = {5'd0, code_len, code_bits, symbol_out};

  `CHC_ASSERT_IMP(a_emit_free, cmd.emit, stat.out_free, "result loaded over a waiting beat")
  `CHC_ASSERT_IMP(a_hit_over, stat.dec_hit, !stat.dec_over, "decode hit and over-long together")
  `CHC_ASSERT_NXT(a_build_unready, cmd.acc && s_axis_tuser == REQ_BUILD, !stat.tbl_ready,
                  "table ready during a build")
  `CHC_ASSERT_IMP(a_emit_state, cmd.emit, state == S_EMIT, "result loaded outside emit")
endmodule

// ===== bench/chc_checker.sv =====
// Checker for the canonical Huffman codec core: watches both stream channels,
// predicts each result from the accepted requests and compares it field by field.
// Depends on chc_pkg.
module chc_checker import chc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  sym;
    logic [14:0] bits;
    logic [3:0]  len;
  } answer_t;

  answer_t answers_q[$];

  logic [3:0]  len_tbl   [NUM_SYMBOLS];
  logic [14:0] code_tbl  [NUM_SYMBOLS];
  logic [8:0]  len_count [16];
  logic [7:0]  by_length [NUM_SYMBOLS];
  logic [3:0]  longest;
  logic        ready;
  logic [15:0] walk_code, walk_first;
  logic [8:0]  walk_index;
  logic [3:0]  walk_len;

  int errors = 0;
  assign errors_o  = errors;
  assign pending_o = answers_q.size();

  initial begin
    foreach (len_tbl[i]) len_tbl[i] = '0;
    longest = '0;
    ready = 1'b0;
    walk_code = '0;
    walk_first = '0;
    walk_index = '0;
    walk_len = '0;
  end

  function automatic void clear_walk();
    walk_code = '0;
    walk_first = '0;
    walk_index = '0;
    walk_len = '0;
  endfunction

  function automatic logic build_tables();
    int maxl, total, pos;
    int code_start [16];
    int code;
    maxl = 0;
    total = 0;
    pos = 0;
    code = 0;
    ready = 1'b0;
    foreach (len_tbl[i]) begin
      if (len_tbl[i] > MAX_CODE_LEN) return 1'b0;
      if (len_tbl[i] > maxl) maxl = int'(len_tbl[i]);
    end
    if (maxl < 1) return 1'b0;
    foreach (len_count[l]) len_count[l] = '0;
    foreach (len_tbl[i]) if (len_tbl[i] != 0) len_count[len_tbl[i]]++;
    for (int l = 1; l <= maxl; l++) total += int'(len_count[l]) << (maxl - l);
    if (total != (1 << maxl)) return 1'b0;
    code_start[0] = 0;
    for (int l = 1; l <= maxl; l++) begin
      code = (code + int'(len_count[l-1])) << 1;
      code_start[l] = code;
    end
    foreach (len_tbl[i]) begin
      if (len_tbl[i] != 0) begin
        code_tbl[i] = code_start[len_tbl[i]][14:0];
        code_start[len_tbl[i]]++;
      end else begin
        code_tbl[i] = '0;
      end
    end
    for (int l = 1; l <= maxl; l++)
      foreach (len_tbl[i]) if (len_tbl[i] == l) by_length[pos++] = i[7:0];
    longest = maxl[3:0];
    ready = 1'b1;
    return 1'b1;
  endfunction

  task automatic predict_answer(logic [1:0] req, logic [7:0] sym, logic [3:0] len,
                                logic bit_in);
    answer_t a;
    logic [3:0] n;
    logic [8:0] cnt;
    int k;
    a = '0;
    case (req)
      REQ_LOAD: begin
        len_tbl[sym] = len;
        ready = 1'b0;
        clear_walk();
        return;
      end
      REQ_BUILD: begin
        a.status = build_tables() ? ST_BUILT : ST_REJECTED;
        clear_walk();
      end
      default: begin
        if (!ready) begin
          a.status = ST_NOTREADY;
        end else if (req == REQ_ENCODE) begin
          a.status = ST_ENCODED;
          a.bits = code_tbl[sym];
          a.len = len_tbl[sym];
        end else begin
          n = walk_len + 4'd1;
          cnt = len_count[n];
          walk_code = walk_code | 16'(bit_in);
          if (walk_code >= walk_first && (walk_code - walk_first) < 16'(cnt)) begin
            k = int'(walk_index) + int'(walk_code - walk_first);
            a.status = ST_DECODED;
            a.sym = (k < NUM_SYMBOLS) ? by_length[k] : 8'd0;
            clear_walk();
          end else begin
            walk_index = walk_index + cnt;
            walk_first = (walk_first + 16'(cnt)) << 1;
            walk_code = walk_code << 1;
            walk_len = n;
            if (walk_len < longest) return;
            a.status = ST_OVERLONG;
            clear_walk();
          end
        end
      end
    endcase
    answers_q.push_back(a);
  endtask

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[22:8], m_axis_tdata[26:23]};
      if (answers_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: status %0d", got.status);
      end else begin
        want = answers_q.pop_front();
        if (got != want || m_axis_tdata[31:27] != '0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected st %0d sym %0d code %h len %0d,",
                     want.status, want.sym, want.bits, want.len,
                     " got st %0d sym %0d code %h len %0d",
                     got.status, got.sym, got.bits, got.len);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_answer(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[11:8], s_axis_tdata[12]);
  end
endmodule

// ===== bench/tb_top.sv =====
// Top of the canonical Huffman codec core testbench: clock, reset, request stimulus
// with random idling, and the verdict. Depends on chc_pkg, chc_checker and the core.
module tb_top import chc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = REQ_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  int          errors, pending;

  int sent = 0;
  int tx_idle = 26;
  int rx_idle = 65;
  logic [3:0] shadow_len [NUM_SYMBOLS];
  int plan_len[$];
  int plan_sym[$];

  canonical_huffman_codec_core i_dut (.*);

  chc_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle);
  end

  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end

  task automatic send(logic [1:0] req, logic [7:0] sym, logic [3:0] len, logic bit_in);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {3'b000, bit_in, len, sym};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (req == REQ_LOAD) shadow_len[sym] = len;
    sent++;
    if (sent == 317) begin
      tx_idle = 65;
      rx_idle = 26;
    end else if (sent == 634) begin
      tx_idle = 0;
      rx_idle = 0;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic build_table();
    drain();
    send(REQ_BUILD, 8'($urandom), 4'($urandom), 1'($urandom));
  endtask

  task automatic load_plan();
    logic used [NUM_SYMBOLS];
    foreach (used[i]) used[i] = 1'b0;
    foreach (plan_sym[j]) used[plan_sym[j]] = 1'b1;
    foreach (shadow_len[i])
      if (shadow_len[i] != 0 && !used[i]) send(REQ_LOAD, 8'(i), 4'd0, 1'($urandom));
    foreach (plan_sym[j])
      send(REQ_LOAD, 8'(plan_sym[j]), 4'(plan_len[j]), 1'($urandom));
  endtask

  task automatic make_plan();
    int target, idx, s, tmp;
    int perm [NUM_SYMBOLS];
    plan_len = '{1, 1};
    target = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 12);
    while (plan_len.size() < target) begin
      idx = $urandom_range(plan_len.size() - 1);
      if (plan_len[idx] < MAX_CODE_LEN) begin
        plan_len[idx]++;
        plan_len.push_back(plan_len[idx]);
      end
    end
    foreach (perm[i]) perm[i] = i;
    for (int i = 0; i < target; i++) begin
      s = $urandom_range(i, NUM_SYMBOLS - 1);
      tmp = perm[i];
      perm[i] = perm[s];
      perm[s] = tmp;
    end
    plan_sym = {};
    for (int i = 0; i < target; i++) plan_sym.push_back(perm[i]);
  endtask

  task automatic traffic(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70)
        send(REQ_DECODE, 8'($urandom), 4'($urandom), 1'($urandom));
      else if ($urandom_range(1))
        send(REQ_ENCODE, 8'(plan_sym[$urandom_range(plan_sym.size() - 1)]),
             4'($urandom), 1'($urandom));
      else
        send(REQ_ENCODE, 8'($urandom), 4'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int extra;
    foreach (shadow_len[i]) shadow_len[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(REQ_BUILD, 8'd0, 4'd0, 1'b0);
    send(REQ_DECODE, 8'd0, 4'd0, 1'b1);
    send(REQ_ENCODE, 8'd255, 4'd0, 1'b0);
    plan_len = {};
    plan_sym = {};
    for (int l = 1; l <= MAX_CODE_LEN; l++) begin
      plan_len.push_back(l);
      plan_sym.push_back(255 - l);
    end
    plan_len.push_back(MAX_CODE_LEN);
    plan_sym.push_back(255);
    plan_len.push_back(1);
    plan_sym.push_back(0);
    plan_len.delete(0);
    plan_sym.delete(0);
    load_plan();
    build_table();
    for (int i = 0; i < MAX_CODE_LEN; i++) send(REQ_DECODE, 8'd0, 4'd0, 1'b1);
    send(REQ_DECODE, 8'd0, 4'd0, 1'b0);
    send(REQ_ENCODE, 8'd255, 4'd0, 1'b0);
    send(REQ_ENCODE, 8'd0, 4'd0, 1'b0);
    send(REQ_ENCODE, 8'd7, 4'd0, 1'b0);
    send(REQ_DECODE, 8'd0, 4'd0, 1'b1);
    send(REQ_LOAD, 8'd0, 4'd1, 1'b0);
    send(REQ_DECODE, 8'd0, 4'd0, 1'b1);

    while (sent < 950) begin
      make_plan();
      load_plan();
      if ($urandom_range(3) == 0) begin
        extra = $urandom_range(NUM_SYMBOLS - 1);
        if (shadow_len[extra] == 0) begin
          send(REQ_LOAD, 8'(extra), 4'($urandom_range(1, MAX_CODE_LEN)), 1'b0);
          build_table();
          traffic(3);
          send(REQ_LOAD, 8'(extra), 4'd0, 1'b1);
        end
      end
      build_table();
      traffic($urandom_range(40, 80));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
